// File: src/ktre_pkg.sv
// package for the key tree revocation engine: constants and types
`default_nettype none
package ktre_pkg;

  localparam int unsigned MaxLeaves = 1024;
  localparam int unsigned SlotW     = $clog2(MaxLeaves);       // 10
  localparam int unsigned NodeW     = $clog2(2 * MaxLeaves);   // 11
  localparam int unsigned CountW    = 11;
  localparam int unsigned GenBytes  = 16;

  localparam logic [63:0] LcgMul  = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd  = 64'd1442695040888963407;
  localparam logic [63:0] GenSeed = 64'hFEDCBA9876543210;

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_REVOKE  = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_SESSION = 3'd4,
    CMD_NODE    = 3'd5,
    CMD_GROUP   = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_INODE, S_ISESS, S_IGROUP,
    S_SRCH, S_SRCH2, S_SRCH_END,
    S_REV_MARK, S_REV_NODE, S_REV_GROUP,
    S_SESS_RD, S_SESS_WT, S_NODE_RD, S_NODE_WT, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [10:0] slot;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        revoked;
    logic [10:0] leaf_no;
    logic [3:0]  renew_cnt;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } rsp_t;

endpackage
`default_nettype wire

// File: src/ktre_if.sv
// valid/ready channel interface carrying one item
`default_nettype none
interface ktre_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ktre_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ktre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// File: src/ktre_keygen.sv
// lcg key generator: one generator step per cycle, 16 steps per key
`default_nettype none
module ktre_keygen (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output      logic         busy_o,
  output      logic         done_o,
  output      logic [127:0] key_o
);
  import ktre_pkg::*;

  logic [63:0]  gen_q, gen_d;
  logic [127:0] key_q;
  logic [4:0]   cnt_q;
  logic         done_q;

  // 64-bit product from three 32x32 partial products; high-by-high falls off the top
  logic [63:0] prod_ll;
  logic [31:0] prod_lh, prod_hl;
  always_comb begin
    prod_ll = {32'd0, gen_q[31:0]} * {32'd0, LcgMul[31:0]};
    prod_lh = gen_q[31:0] * LcgMul[63:32];
    prod_hl = gen_q[63:32] * LcgMul[31:0];
    gen_d   = prod_ll + {prod_lh + prod_hl, 32'd0} + LcgAdd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= GenSeed;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && cnt_q == '0) begin
        cnt_q <= 5'(GenBytes);
      end else if (cnt_q != '0) begin
        gen_q <= gen_d;
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q != '0) begin
      key_q <= {key_q[119:0], gen_d[63:56]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign key_o  = key_q;
endmodule
`default_nettype wire

// File: src/key_tree_revocation_engine.sv
// top level of the key tree revocation engine
`default_nettype none
// Binary key tree revocation engine. One command is taken at a time and
// gives one result. Node keys, leaf ids, session keys and revoked marks sit
// in single-port rams with registered read; ids, session keys and marks are
// cleared by a sweep over all 1024 slots at the start of every init, and
// after reset the same sweep runs before the first command is taken. Keys
// come from a 64-bit lcg stepping once a cycle; each key takes a start, 16
// steps and a write. Init then makes keys for the 2*span nodes, the n
// session slots and the group; an id search runs over min(span,1024) slots
// (a query for a revoked id scans twice), and a revoke writes the mark,
// renews each ancestor of the leaf up to the root and then the group key.
// A load, a group key read or an unused code goes straight to the result
// state; a node key read first passes a ram read and a wait state, as does
// a session key read after its search hit. The next item is taken the
// cycle after the result has been accepted.
module key_tree_revocation_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  ktre_if.sink             req_if,
  ktre_if.source           rsp_if
);
  import ktre_pkg::*;

  state_e state_q, state_d;

  logic [10:0] vcount_q;
  logic [10:0] span_q, span_d;
  logic [10:0] n_q, n_d;
  req_t        req_q;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic [11:0] idx_q, idx_d;      // sweep / search index
  logic [11:0] cur_q, cur_d;      // tree walk node
  logic [3:0]  ucnt_q, ucnt_d;
  logic        pass_q, pass_d;    // 0 active-only, 1 any match
  logic        req_take;
  logic [127:0] group_q;
  logic        group_we;

  // rams
  logic         nk_we, id_we, sk_we, rv_we;
  logic [NodeW-1:0] nk_addr;
  logic [SlotW-1:0] id_addr, sk_addr, rv_addr;
  logic [127:0] nk_wd, id_wd, sk_wd, nk_rd, id_rd, sk_rd;
  logic         rv_wd, rv_rd;

  ktre_ram #(.Width(128), .Depth(2*MaxLeaves)) u_node (
    .clk_i, .we_i(nk_we), .addr_i(nk_addr), .wdata_i(nk_wd), .rdata_o(nk_rd));
  ktre_ram #(.Width(128), .Depth(MaxLeaves)) u_id (
    .clk_i, .we_i(id_we), .addr_i(id_addr), .wdata_i(id_wd), .rdata_o(id_rd));
  ktre_ram #(.Width(128), .Depth(MaxLeaves)) u_sess (
    .clk_i, .we_i(sk_we), .addr_i(sk_addr), .wdata_i(sk_wd), .rdata_o(sk_rd));
  ktre_ram #(.Width(1), .Depth(MaxLeaves)) u_mark (
    .clk_i, .we_i(rv_we), .addr_i(rv_addr), .wdata_i(rv_wd), .rdata_o(rv_rd));

  // key generator
  logic         kg_start, kg_busy, kg_done;
  logic [127:0] kg_key;
  ktre_keygen u_keygen (
    .clk_i, .rst_ni, .start_i(kg_start), .busy_o(kg_busy), .done_o(kg_done),
    .key_o(kg_key));

  // derived limits
  logic [11:0] slot_lim, node_lim;
  always_comb begin
    slot_lim = (span_q > 11'(MaxLeaves)) ? 12'(MaxLeaves) : {1'b0, span_q};
    node_lim = {span_q, 1'b0};
  end

  // span for init: smallest power of two >= n, n saturated
  logic [10:0] sat_n, pow_span;
  always_comb begin
    sat_n = (vcount_q > 11'(MaxLeaves)) ? 11'(MaxLeaves) : vcount_q;
    pow_span = 11'd1;
    for (int b = 0; b < 10; b++) begin
      if (sat_n > (11'd1 << b)) begin
        pow_span = 11'd2 << b;
      end
    end
  end

  logic [SlotW-1:0] slot_s;
  logic [10:0]      leaf_s;
  logic             id_hit;
  assign slot_s = idx_q[SlotW-1:0] - SlotW'(1);
  assign leaf_s = span_q - 11'd1 + 11'(slot_s);
  assign id_hit = (id_rd == {req_q.id_high, req_q.id_low});

  assign req_take = req_if.valid && req_if.ready;
  assign req_if.ready = (state_q == S_IDLE) && !rsp_valid_q;

  always_comb begin
    state_d = state_q;
    span_d = span_q; n_d = n_q;
    rsp_d = rsp_q; rsp_valid_d = rsp_valid_q;
    idx_d = idx_q; cur_d = cur_q; ucnt_d = ucnt_q; pass_d = pass_q;
    nk_we = 1'b0; id_we = 1'b0; sk_we = 1'b0; rv_we = 1'b0;
    nk_addr = cur_q[NodeW-1:0]; nk_wd = kg_key;
    id_addr = idx_q[SlotW-1:0]; id_wd = '0;
    sk_addr = idx_q[SlotW-1:0]; sk_wd = kg_key;
    rv_addr = idx_q[SlotW-1:0]; rv_wd = 1'b0;
    kg_start = 1'b0; group_we = 1'b0;

    if (rsp_valid_q && rsp_if.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_take) begin
          rsp_d = '0;
          idx_d = '0; pass_d = 1'b0; ucnt_d = '0;
          unique case (cmd_e'(req_if.data.command))
            CMD_INIT: begin
              span_d = pow_span; n_d = sat_n;
              state_d = S_CLR;
            end
            CMD_LOAD: begin
              if ({1'b0, req_if.data.slot} >= slot_lim) begin
                rsp_d.status = ST_RANGE;
              end else begin
                id_we = 1'b1;
                id_addr = req_if.data.slot[SlotW-1:0];
                id_wd = {req_if.data.id_high, req_if.data.id_low};
                rsp_d.leaf_no = span_q - 11'd1 + req_if.data.slot;
              end
              state_d = S_OUT;
            end
            CMD_REVOKE, CMD_QUERY, CMD_SESSION: begin
              state_d = S_SRCH;
            end
            CMD_NODE: begin
              if ({1'b0, req_if.data.slot} >= node_lim) begin
                rsp_d.status = ST_RANGE;
                state_d = S_OUT;
              end else begin
                cur_d = {1'b0, req_if.data.slot};
                state_d = S_NODE_RD;
              end
            end
            CMD_GROUP: begin
              rsp_d.key_high = group_q[127:64];
              rsp_d.key_low  = group_q[63:0];
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      // clear ids, session keys and marks, one slot per cycle
      S_CLR: begin
        id_we = 1'b1; rv_we = 1'b1; sk_we = 1'b1; sk_wd = '0;
        idx_d = idx_q + 12'd1;
        if (idx_q == 12'(MaxLeaves - 1)) begin
          idx_d = '0; cur_d = '0;
          state_d = (req_q.command == CMD_INIT) ? S_INODE : S_IDLE;
        end
      end
      S_INODE: begin
        if (!kg_busy && !kg_done) kg_start = 1'b1;
        if (kg_done) begin
          nk_we = 1'b1;
          cur_d = cur_q + 12'd1;
          if (cur_q + 12'd1 >= node_lim) begin
            idx_d = '0;
            state_d = (n_q == '0) ? S_IGROUP : S_ISESS;
          end
        end
      end
      S_ISESS: begin
        if (!kg_busy && !kg_done) kg_start = 1'b1;
        if (kg_done) begin
          sk_we = 1'b1;
          idx_d = idx_q + 12'd1;
          if (idx_q + 12'd1 >= {1'b0, n_q}) state_d = S_IGROUP;
        end
      end
      S_IGROUP: begin
        if (!kg_busy && !kg_done) kg_start = 1'b1;
        if (kg_done) begin
          group_we = 1'b1;
          state_d = S_OUT;
        end
      end
      // search: issue read of slot idx, check data of previous slot
      S_SRCH: begin
        idx_d = idx_q + 12'd1;
        state_d = S_SRCH2;
      end
      S_SRCH2: begin
        if (id_hit && (pass_q || !rv_rd)) begin
          rsp_d.leaf_no = leaf_s;
          idx_d = {2'b0, slot_s};
          if (pass_q) begin
            rsp_d.revoked = rv_rd;
            state_d = S_OUT;
          end else begin
            unique case (cmd_e'(req_q.command))
              CMD_REVOKE: state_d = S_REV_MARK;
              CMD_SESSION: state_d = S_SESS_RD;
              default: state_d = S_OUT;
            endcase
          end
        end else if (idx_q >= slot_lim) begin
          state_d = S_SRCH_END;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH_END: begin
        if (req_q.command == CMD_QUERY && !pass_q) begin
          pass_d = 1'b1; idx_d = '0;
          state_d = S_SRCH;
        end else begin
          rsp_d.status = ST_NOTFOUND;
          state_d = S_OUT;
        end
      end
      S_REV_MARK: begin
        rv_we = 1'b1; rv_wd = 1'b1;
        sk_we = 1'b1; sk_wd = '0;
        cur_d = {1'b0, rsp_q.leaf_no};
        state_d = (rsp_q.leaf_no == '0) ? S_REV_GROUP : S_REV_NODE;
      end
      S_REV_NODE: begin
        nk_addr = NodeW'((cur_q - 12'd1) >> 1);
        if (!kg_busy && !kg_done) kg_start = 1'b1;
        if (kg_done) begin
          nk_we = 1'b1;
          cur_d = (cur_q - 12'd1) >> 1;
          ucnt_d = ucnt_q + 4'd1;
          if (((cur_q - 12'd1) >> 1) == '0) state_d = S_REV_GROUP;
        end
      end
      S_REV_GROUP: begin
        if (!kg_busy && !kg_done) kg_start = 1'b1;
        if (kg_done) begin
          group_we = 1'b1;
          rsp_d.renew_cnt = ucnt_q;
          rsp_d.key_high = kg_key[127:64];
          rsp_d.key_low = kg_key[63:0];
          state_d = S_OUT;
        end
      end
      S_SESS_RD: state_d = S_SESS_WT;
      S_SESS_WT: begin
        rsp_d.key_high = sk_rd[127:64];
        rsp_d.key_low = sk_rd[63:0];
        state_d = S_OUT;
      end
      S_NODE_RD: state_d = S_NODE_WT;
      S_NODE_WT: begin
        rsp_d.key_high = nk_rd[127:64];
        rsp_d.key_low = nk_rd[63:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;          // sweep after reset
      vcount_q <= 11'd8;
      span_q <= 11'd1;
      n_q <= '0;
      rsp_valid_q <= 1'b0;
      idx_q <= '0;
      cur_q <= '0;
      ucnt_q <= '0;
      pass_q <= 1'b0;
      group_q <= '0;
      req_q <= '{command: CMD_NONE, slot: '0, id_high: '0, id_low: '0};
    end else begin
      state_q <= state_d;
      span_q <= span_d;
      n_q <= n_d;
      rsp_valid_q <= rsp_valid_d;
      idx_q <= idx_d;
      cur_q <= cur_d;
      ucnt_q <= ucnt_d;
      pass_q <= pass_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (group_we) group_q <= kg_key;
      if (req_take) req_q <= req_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.data  = rsp_q;

  // assertions
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_if.ready) else $error("item taken while busy");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> rsp_if.valid) else $error("result lost");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid |-> rsp_if.data.status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

// File: test/tb_key_tree_revocation_engine.sv
// testbench for the key tree revocation engine: directed and random commands checked against a tree predictor
`default_nettype none
module tb_key_tree_revocation_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ktre_pkg::*;

  localparam int unsigned NodeMax = 2 * MaxLeaves;

  // key tree predictor and store of expected results
  class key_tree_scoreboard;
    logic [63:0] node_hi[NodeMax];
    logic [63:0] node_lo[NodeMax];
    logic [63:0] id_hi[MaxLeaves];
    logic [63:0] id_lo[MaxLeaves];
    logic [63:0] sess_hi[MaxLeaves];
    logic [63:0] sess_lo[MaxLeaves];
    bit          marked[MaxLeaves];
    logic [63:0] group_hi, group_lo;
    logic [63:0] lcg;
    int unsigned span;
    int unsigned vehicles;
    rsp_t        pending_rsp[$];
    int unsigned errors;

    function void clear_all();
      for (int i = 0; i < NodeMax; i++) begin
        node_hi[i] = '0;
        node_lo[i] = '0;
      end
      for (int i = 0; i < MaxLeaves; i++) begin
        id_hi[i] = '0;
        id_lo[i] = '0;
        sess_hi[i] = '0;
        sess_lo[i] = '0;
        marked[i] = 1'b0;
      end
    endfunction

    function void reset_state();
      clear_all();
      group_hi = '0;
      group_lo = '0;
      lcg = GenSeed;
      span = 1;
      vehicles = 8;
      errors = 0;
    endfunction

    // sixteen lcg steps, top byte of each step, byte 0 first
    function void next_key(output logic [63:0] hi, output logic [63:0] lo);
      logic [127:0] k;
      k = '0;
      for (int i = 0; i < GenBytes; i++) begin
        lcg = lcg * LcgMul + LcgAdd;
        k = {k[119:0], lcg[63:56]};
      end
      hi = k[127:64];
      lo = k[63:0];
    endfunction

    function int unsigned slot_count();
      return (span < MaxLeaves) ? span : MaxLeaves;
    endfunction

    function int unsigned node_count();
      return (2 * span < NodeMax) ? 2 * span : NodeMax;
    endfunction

    function int search_id(logic [63:0] hi, logic [63:0] lo, bit active_only);
      for (int s = 0; s < slot_count(); s++) begin
        if (active_only && marked[s]) continue;
        if (id_hi[s] == hi && id_lo[s] == lo) return s;
      end
      return -1;
    endfunction

    function logic [10:0] leaf_node(int s);
      int unsigned t;
      t = span - 1 + s;
      return t[10:0];
    endfunction

    function void note_item(req_t r);
      rsp_t        e;
      int          s;
      int unsigned n, cur, cnt;
      e = '0;
      case (cmd_e'(r.command))
        CMD_INIT: begin
          n = (vehicles > MaxLeaves) ? MaxLeaves : vehicles;
          span = 1;
          while (span < n) span = span << 1;
          clear_all();
          for (int i = 0; i < node_count(); i++) next_key(node_hi[i], node_lo[i]);
          for (int i = 0; i < n; i++) next_key(sess_hi[i], sess_lo[i]);
          next_key(group_hi, group_lo);
        end
        CMD_LOAD: begin
          if (r.slot >= slot_count()) e.status = ST_RANGE;
          else begin
            id_hi[r.slot] = r.id_high;
            id_lo[r.slot] = r.id_low;
            e.leaf_no = leaf_node(r.slot);
          end
        end
        CMD_REVOKE: begin
          s = search_id(r.id_high, r.id_low, 1'b1);
          if (s < 0) e.status = ST_NOTFOUND;
          else begin
            marked[s] = 1'b1;
            sess_hi[s] = '0;
            sess_lo[s] = '0;
            cur = span - 1 + s;
            cnt = 0;
            // renew every ancestor up to the root
            while (cur != 0) begin
              cur = (cur - 1) / 2;
              if (cur < NodeMax) next_key(node_hi[cur], node_lo[cur]);
              cnt++;
            end
            next_key(group_hi, group_lo);
            e.leaf_no = leaf_node(s);
            e.renew_cnt = cnt[3:0];
            e.key_high = group_hi;
            e.key_low = group_lo;
          end
        end
        CMD_QUERY: begin
          s = search_id(r.id_high, r.id_low, 1'b1);
          if (s >= 0) e.leaf_no = leaf_node(s);
          else begin
            s = search_id(r.id_high, r.id_low, 1'b0);
            if (s < 0) e.status = ST_NOTFOUND;
            else begin
              e.revoked = marked[s];
              e.leaf_no = leaf_node(s);
            end
          end
        end
        CMD_SESSION: begin
          s = search_id(r.id_high, r.id_low, 1'b1);
          if (s < 0) e.status = ST_NOTFOUND;
          else begin
            e.leaf_no = leaf_node(s);
            e.key_high = sess_hi[s];
            e.key_low = sess_lo[s];
          end
        end
        CMD_NODE: begin
          if (r.slot >= node_count()) e.status = ST_RANGE;
          else begin
            e.key_high = node_hi[r.slot];
            e.key_low = node_lo[r.slot];
          end
        end
        CMD_GROUP: begin
          e.key_high = group_hi;
          e.key_low = group_lo;
        end
        default: ;
      endcase
      pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, a);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d act %0d", $realtime, e.status, a.status);
        errors++;
      end
      if (a.revoked !== e.revoked) begin
        $display("%0t: revoked exp %0d act %0d", $realtime, e.revoked, a.revoked);
        errors++;
      end
      if (a.leaf_no !== e.leaf_no) begin
        $display("%0t: leaf_no exp %0d act %0d", $realtime, e.leaf_no, a.leaf_no);
        errors++;
      end
      if (a.renew_cnt !== e.renew_cnt) begin
        $display("%0t: renew_cnt exp %0d act %0d", $realtime, e.renew_cnt,
                 a.renew_cnt);
        errors++;
      end
      if (a.key_high !== e.key_high) begin
        $display("%0t: key_high exp %h act %h", $realtime, e.key_high, a.key_high);
        errors++;
      end
      if (a.key_low !== e.key_low) begin
        $display("%0t: key_low exp %h act %h", $realtime, e.key_low, a.key_low);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  bit          calm;

  ktre_if #(.T(req_t)) req_if ();
  ktre_if #(.T(rsp_t)) rsp_if ();

  key_tree_revocation_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_if     (req_if.sink),
    .rsp_if     (rsp_if.source)
  );

  key_tree_scoreboard tree_sb;

  // id pool per phase, so that revokes and queries find their vehicles
  logic [63:0] pool_hi[8];
  logic [63:0] pool_lo[8];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: random stall bursts, none once the run calms down
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) tree_sb.check_result(rsp_if.data);
  end

  // valid stays high after a handshake when the next item follows at once
  task automatic send_item(req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (!req_if.ready);
    tree_sb.note_item(r);
  endtask

  task automatic make_item(output req_t r, input cmd_e c, input int unsigned slot,
                           input logic [63:0] hi, input logic [63:0] lo);
    r.command = c;
    r.slot = slot[10:0];
    r.id_high = hi;
    r.id_low = lo;
  endtask

  // let everything outstanding come back before touching the register
  task automatic drain();
    req_if.valid <= 1'b0;
    while (tree_sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vehicles(int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tree_sb.vehicles = v & 11'h7FF;
  endtask

  task automatic fill_pool();
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    pool_hi[7] = '0;  // the empty-slot id
    pool_lo[7] = '0;
  endtask

  task automatic random_item(bit allow_init);
    req_t        r;
    int unsigned pick, sl, k;
    logic [63:0] hi, lo;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end else begin
      hi = pool_hi[k];
      lo = pool_lo[k];
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      sl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                       : $urandom_range(0, tree_sb.slot_count() - 1);
      make_item(r, CMD_LOAD, sl, hi, lo);
    end else if (pick < 40) make_item(r, CMD_REVOKE, $urandom_range(0, 2047), hi, lo);
    else if (pick < 55) make_item(r, CMD_QUERY, $urandom_range(0, 2047), hi, lo);
    else if (pick < 70) make_item(r, CMD_SESSION, $urandom_range(0, 2047), hi, lo);
    else if (pick < 83) begin
      sl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                       : $urandom_range(0, tree_sb.node_count() - 1);
      make_item(r, CMD_NODE, sl, hi, lo);
    end else if (pick < 92) make_item(r, CMD_GROUP, $urandom_range(0, 2047), hi, lo);
    else if (pick < 96 && allow_init) make_item(r, CMD_INIT, $urandom_range(0, 2047), hi, lo);
    else make_item(r, CMD_NONE, $urandom_range(0, 2047), hi, lo);
    send_item(r);
  endtask

  task automatic run_phase(int unsigned vehicles, int unsigned items, bit allow_init);
    req_t r;
    drain();
    write_vehicles(vehicles);
    fill_pool();
    make_item(r, CMD_INIT, 0, '0, '0);
    send_item(r);
    // seed the leaves with pool ids before the random mix
    for (int i = 0; i < 8 && i < tree_sb.slot_count(); i++) begin
      make_item(r, CMD_LOAD, $urandom_range(0, tree_sb.slot_count() - 1),
                pool_hi[i], pool_lo[i]);
      send_item(r);
    end
    for (int i = 0; i < items; i++) random_item(allow_init);
  endtask

  task automatic directed_items();
    req_t        r;
    logic [63:0] a_hi, a_lo;
    a_hi = 64'h0123456789ABCDEF;
    a_lo = 64'hFEDCBA9876543210;
    make_item(r, CMD_INIT, 0, '0, '0);                 send_item(r);
    make_item(r, CMD_LOAD, 0, a_hi, a_lo);             send_item(r);
    make_item(r, CMD_LOAD, 7, '1, '1);                 send_item(r); // last leaf slot
    make_item(r, CMD_LOAD, 8, a_hi, a_lo);             send_item(r); // just out of range
    make_item(r, CMD_LOAD, 2047, a_hi, a_lo);          send_item(r);
    make_item(r, CMD_QUERY, 0, a_hi, a_lo);            send_item(r);
    make_item(r, CMD_SESSION, 0, a_hi, a_lo);          send_item(r);
    make_item(r, CMD_REVOKE, 0, a_hi, a_lo);           send_item(r);
    make_item(r, CMD_QUERY, 0, a_hi, a_lo);            send_item(r); // now revoked
    make_item(r, CMD_REVOKE, 0, a_hi, a_lo);           send_item(r); // not found
    make_item(r, CMD_SESSION, 0, a_hi, a_lo);          send_item(r); // not found
    make_item(r, CMD_QUERY, 0, 64'h5A5A, 64'hA5A5);    send_item(r); // unknown id
    make_item(r, CMD_QUERY, 0, '0, '0);                send_item(r); // empty slot match
    make_item(r, CMD_REVOKE, 0, '0, '0);               send_item(r); // revoke empty slot
    make_item(r, CMD_REVOKE, 0, '1, '1);               send_item(r);
    make_item(r, CMD_NODE, 0, '0, '0);                 send_item(r); // root
    make_item(r, CMD_NODE, 15, '0, '0);                send_item(r); // last node
    make_item(r, CMD_NODE, 16, '0, '0);                send_item(r); // out of range
    make_item(r, CMD_NODE, 2047, '0, '0);              send_item(r);
    make_item(r, CMD_GROUP, 0, '0, '0);                send_item(r);
    make_item(r, CMD_NONE, 2047, '1, '1);              send_item(r); // unused code
    make_item(r, CMD_LOAD, 0, a_hi, a_lo);             send_item(r); // reload revoked slot
    make_item(r, CMD_QUERY, 0, a_hi, a_lo);            send_item(r); // still marked
  endtask

  initial begin
    tree_sb = new();
    tree_sb.reset_state();
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value first, then small, odd, both extremes and a near-full tree
    write_vehicles(8);
    fill_pool();
    directed_items();
    for (int i = 0; i < 130; i++) random_item(1'b1);
    run_phase(1, 80, 1'b1);
    run_phase(5, 100, 1'b1);
    run_phase(1024, 25, 1'b0);
    run_phase(1023, 25, 1'b0);
    drain();
    calm = 1'b1;
    run_phase(3, 150, 1'b1);

    drain();
    repeat (100) @(posedge clk_i);
    if (tree_sb.errors == 0 && tree_sb.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/ktre_pkg.sv
src/ktre_if.sv
src/ktre_ram.sv
src/ktre_keygen.sv
src/key_tree_revocation_engine.sv
test/tb_key_tree_revocation_engine.sv
